FILE: rtl/mrcc_pkg.sv
package mrcc_pkg;

   // Stage counts and slope fields
   localparam int DEF_MAX_STAGES = 4;
   localparam int NUM_SLOPES     = 4;
   localparam int STAGE_W        = 2;

   // Datapath widths
   localparam int PROD_W  = 50;
   localparam int ACC_W   = 50;
   localparam int DEN_W   = 33;
   localparam int COEF_SH = 14;
   localparam int TERM_SH = 16;

   // Divider
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   // Smallest denominator: 0.002 in Q16.16
   localparam logic [DEN_W-1:0] MIN_DENOM = 33'd131;

   // Configuration register map
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_STEP_SIZE   = 3'd0,
      REG_CHANGE_GOAL = 3'd1,
      REG_STAGE_COUNT = 3'd2,
      REG_WEIGHT0     = 3'd3,
      REG_WEIGHT1     = 3'd4,
      REG_WEIGHT2     = 3'd5,
      REG_WEIGHT3     = 3'd6
   } csr_reg_type;

   localparam logic [31:0]        RST_STEP_SIZE   = 32'h0001_0000;
   localparam logic [31:0]        RST_CHANGE_GOAL = 32'h0001_0000;
   localparam logic [2:0]         RST_STAGE_COUNT = 3'd1;
   localparam logic signed [15:0] RST_WEIGHT0     = 16'sd16384;
   localparam logic signed [15:0] RST_WEIGHT_REST = 16'sd0;

   typedef struct packed {
      logic signed [31:0] old_temperature;
      logic signed [31:0] slope_stage0;
      logic signed [31:0] slope_stage1;
      logic signed [31:0] slope_stage2;
      logic signed [31:0] slope_stage3;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic [31:0] criterion;
      logic        too_big;
   } rsp_type;

   typedef struct packed {
      logic [31:0] step_size;
      logic [31:0] change_goal;
      logic [2:0]  stage_count;
   } cfg_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      SEL_COEF = 2'd0,
      SEL_LOW  = 2'd1,
      SEL_HIGH = 2'd2
   } mac_sel_type;

   typedef struct packed {
      logic        clear;
      logic        mul_en;
      mac_sel_type sel;
      logic        coef_en;
      logic        add_full;
      logic        add_low;
   } mac_ctrl_type;

   // Saturate a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-32:0] top_bits;
      logic signed [31:0] res;
      top_bits = x[ACC_W-1:31];
      if (top_bits == '0 || top_bits == '1) begin
         res = x[31:0];
      end else if (x[ACC_W-1]) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'sh7fff_ffff;
      end
      return res;
   endfunction

endpackage

FILE: rtl/max_relative_change_check_core.sv
// Channel  Ports                                   Handshake         Payload
// req      req_valid req_stall req_data            valid && !stall   req_type (element)
// rsp      rsp_valid rsp_stall rsp_data            valid && !stall   rsp_type (criterion)
// csr      csr_valid csr_ready csr_index csr_data  valid && ready    register index, 32-bit data
//
// For each of the n active stages of an element, the shared 33x17 multiplier runs
// the coefficient, settle, low-digit and high-digit phases; then the radix-2 divider
// runs its 32 steps. req_stall is low only while no element is at work.
// A result waits in the output register; a last element finds it still stalled and
// holds in its final state until the register frees. Reset is synchronous and
// restores the register defaults and a zero running maximum.
module max_relative_change_check_core import mrcc_pkg::*; #(
   parameter int MAX_STAGES = DEF_MAX_STAGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL   = 8'b0000_0010,
      ST_SUM   = 8'b0000_0100,
      ST_CHG   = 8'b0000_1000,
      ST_DEN   = 8'b0001_0000,
      ST_START = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type                          state_ff, state_in;
   logic [STAGE_W-1:0]                 stage_ff, stage_in;
   logic [1:0]                         phase_ff, phase_in;
   req_type                            req_ff, req_in;
   logic signed [31:0]                 change_ff, change_in;
   logic [31:0]                        absc_ff, absc_in;
   logic [DEN_W-1:0]                   denom_ff, denom_in;
   logic [31:0]                        max_ff, max_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rsp_type                            rsp_ff, rsp_in;

   cfg_type                            cfg;
   logic signed [MAX_STAGES-1:0][15:0] weights;
   mac_ctrl_type                       mac_ctrl;
   logic signed [ACC_W-1:0]            acc;
   logic signed [15:0]                 weight_sel;
   logic signed [31:0]                 slope_sel;
   logic [STAGE_W-1:0]                 last_stage;
   logic [2:0]                         count_clamped;
   logic                               accept;
   logic                               emit;
   logic                               div_start;
   logic [31:0]                        div_quot;
   logic                               div_busy;
   logic                               div_done;
   logic signed [32:0]                 new_temp;
   logic [31:0]                        abs_old;
   logic [32:0]                        abs_new;
   logic [DEN_W-1:0]                   denom_sum;
   logic [31:0]                        max_next;
   logic [31:0]                        crit;
   logic [34:0]                        crit_x5;
   logic [34:0]                        goal_x6;

   assign csr_ready = 1'b1;

   mrcc_csr #(
      .MAX_STAGES(MAX_STAGES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg),
      .weights  (weights)
   );

   // Clamp the stage count to one through MAX_STAGES
   always_comb begin
      if (cfg.stage_count == 3'd0) begin
         count_clamped = 3'd1;
      end else if (cfg.stage_count > 3'(MAX_STAGES)) begin
         count_clamped = 3'(MAX_STAGES);
      end else begin
         count_clamped = cfg.stage_count;
      end
      last_stage = STAGE_W'(count_clamped - 3'd1);
   end

   // Select the current stage's weight and slope
   always_comb begin
      weight_sel = '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
         if (stage_ff == STAGE_W'(i)) begin
            weight_sel = weights[i];
         end
      end
      case (stage_ff)
         2'd0:    slope_sel = req_ff.slope_stage0;
         2'd1:    slope_sel = req_ff.slope_stage1;
         2'd2:    slope_sel = req_ff.slope_stage2;
         2'd3:    slope_sel = req_ff.slope_stage3;
         default: slope_sel = req_ff.slope_stage0;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = (state_ff == ST_START);

   // Sequence the multiplier: coefficient, settle, low digit, high digit
   always_comb begin
      mac_ctrl          = '0;
      mac_ctrl.sel      = SEL_COEF;
      mac_ctrl.clear    = accept;
      if (state_ff == ST_MUL) begin
         case (phase_ff)
            2'd0: begin
               mac_ctrl.sel      = SEL_COEF;
               mac_ctrl.mul_en   = 1'b1;
               mac_ctrl.add_full = (stage_ff != '0);
            end
            2'd1: begin
               mac_ctrl.coef_en  = 1'b1;
            end
            2'd2: begin
               mac_ctrl.sel      = SEL_LOW;
               mac_ctrl.mul_en   = 1'b1;
            end
            2'd3: begin
               mac_ctrl.sel      = SEL_HIGH;
               mac_ctrl.mul_en   = 1'b1;
               mac_ctrl.add_low  = 1'b1;
            end
            default: begin
               mac_ctrl.sel      = SEL_COEF;
            end
         endcase
      end else if (state_ff == ST_SUM) begin
         mac_ctrl.add_full = 1'b1;
      end
   end

   mrcc_mac u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .step_size (cfg.step_size),
      .weight    (weight_sel),
      .slope     (slope_sel),
      .acc       (acc)
   );

   mrcc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (absc_ff),
      .denom (denom_ff),
      .quot  (div_quot),
      .busy  (div_busy),
      .done  (div_done)
   );

   // Denominator terms
   always_comb begin
      new_temp  = {req_ff.old_temperature[31], req_ff.old_temperature}
                + {change_ff[31], change_ff};
      abs_old   = req_ff.old_temperature[31] ? 32'(-req_ff.old_temperature)
                                             : req_ff.old_temperature;
      abs_new   = new_temp[32] ? 33'(-new_temp) : new_temp;
      denom_sum = {1'b0, abs_old} + abs_new;
   end

   // Running maximum and criterion
   always_comb begin
      max_next = (div_quot > max_ff) ? div_quot : max_ff;
      crit     = max_next[31] ? 32'hffff_ffff : {max_next[30:0], 1'b0};
      crit_x5  = {1'b0, crit, 2'b00} + {3'b000, crit};
      goal_x6  = {1'b0, cfg.change_goal, 2'b00} + {2'b00, cfg.change_goal, 1'b0};
      emit     = (state_ff == ST_DONE) && req_ff.last_element
              && !(rsp_valid_ff && rsp_stall);
   end

   // Advance the sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      req_in       = req_ff;
      change_in    = change_ff;
      absc_in      = absc_ff;
      denom_in     = denom_ff;
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               stage_in = '0;
               phase_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (stage_ff == last_stage) begin
                  state_in = ST_SUM;
               end else begin
                  stage_in = stage_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            state_in = ST_CHG;
         end
         ST_CHG: begin
            change_in = sat32(acc);
            state_in  = ST_DEN;
         end
         ST_DEN: begin
            absc_in  = change_ff[31] ? 32'(-change_ff) : change_ff;
            denom_in = (denom_sum < MIN_DENOM) ? MIN_DENOM : denom_sum;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!req_ff.last_element) begin
               max_in   = max_next;
               state_in = ST_IDLE;
            end else if (emit) begin
               rsp_in.criterion = crit;
               rsp_in.too_big   = crit_x5 > goal_x6;
               rsp_valid_in     = 1'b1;
               max_in           = '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stage_ff  <= stage_in;
      phase_ff  <= phase_in;
      req_ff    <= req_in;
      change_ff <= change_in;
      absc_ff   <= absc_in;
      denom_ff  <= denom_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted transaction did not start the multiply sequence");

   a_div_running : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (div_busy || div_done))
      else $error("waiting on a divider that is not running");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE) && $past(req_ff.last_element))
      else $error("result raised outside the final state of a last element");

   a_max_cleared : assert property (@(posedge clock) disable iff (reset)
      emit |=> max_ff == '0)
      else $error("running maximum not cleared after a result");

endmodule

FILE: rtl/mrcc_csr.sv
module mrcc_csr import mrcc_pkg::*; #(
   parameter int MAX_STAGES = DEF_MAX_STAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [CSR_INDEX_W-1:0]              wr_index,
   input  logic [31:0]                         wr_data,
   output cfg_type                             cfg,
   output logic signed [MAX_STAGES-1:0][15:0]  weights
);

   cfg_type                            cfg_ff;
   logic signed [MAX_STAGES-1:0][15:0] weights_ff;

   // Write scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size   <= RST_STEP_SIZE;
         cfg_ff.change_goal <= RST_CHANGE_GOAL;
         cfg_ff.stage_count <= RST_STAGE_COUNT;
      end else if (wr_en) begin
         if (wr_index == REG_STEP_SIZE) begin
            cfg_ff.step_size <= wr_data;
         end
         if (wr_index == REG_CHANGE_GOAL) begin
            cfg_ff.change_goal <= wr_data;
         end
         if (wr_index == REG_STAGE_COUNT) begin
            cfg_ff.stage_count <= wr_data[2:0];
         end
      end
   end

   // Write stage weights; indexes beyond the stored stages drop
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
         if (reset) begin
            weights_ff[i] <= (i == 0) ? RST_WEIGHT0 : RST_WEIGHT_REST;
         end else if (wr_en && wr_index == CSR_INDEX_W'(int'(REG_WEIGHT0) + i)) begin
            weights_ff[i] <= wr_data[15:0];
         end
      end
   end

   assign cfg     = cfg_ff;
   assign weights = weights_ff;

endmodule

FILE: rtl/mrcc_mac.sv
module mrcc_mac import mrcc_pkg::*; (
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic [31:0]              step_size,
   input  logic signed [15:0]       weight,
   input  logic signed [31:0]       slope,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [32:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [31:0]       coef_ff, coef_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // Pick operands: weight by step, then coefficient by low and high slope digits
   always_comb begin
      case (ctrl.sel)
         SEL_COEF: begin
            mul_a = {1'b0, step_size};
            mul_b = {weight[15], weight};
         end
         SEL_LOW: begin
            mul_a = {coef_ff[31], coef_ff};
            mul_b = {1'b0, slope[15:0]};
         end
         SEL_HIGH: begin
            mul_a = {coef_ff[31], coef_ff};
            mul_b = {slope[31], slope[31:16]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Hold or load product and coefficient
   always_comb begin
      prod_in = ctrl.mul_en ? mul_p : prod_ff;
      coef_in = ctrl.coef_en ? sat32(prod_ff >>> COEF_SH) : coef_ff;
   end

   // Accumulate: low digit product with floor shift, high digit product in full
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.add_full) begin
         acc_in = acc_ff + prod_ff;
      end else if (ctrl.add_low) begin
         acc_in = acc_ff + (prod_ff >>> TERM_SH);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/mrcc_div.sv
module mrcc_div import mrcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       numer,
   input  logic [DEN_W-1:0]  denom,
   output logic [31:0]       quot,
   output logic              busy,
   output logic              done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [31:0]          q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       rem_sub;
   logic                 fits;

   // One quotient bit per step; dividend bits shift out of the quotient register
   always_comb begin
      rem_sh  = {rem_ff, q_ff[31]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         // Load: the top 16 bits of the scaled dividend seed the remainder
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         rem_in  = DEN_W'(numer[31:16]);
         q_in    = {numer[15:0], 16'h0000};
         ovf_in  = DEN_W'(numer[31:16]) >= denom;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         q_in   = {q_ff[30:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   // Saturate when the quotient needs more than 32 bits
   assign quot = ovf_ff ? 32'hffff_ffff : q_ff;
   assign busy = busy_ff;
   assign done = done_ff;

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

FILE: tb/max_relative_change_check_core_tb.sv
`timescale 1ns / 1ps

module max_relative_change_check_core_tb;
   import mrcc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int    DRAIN_CYCLES = 4 * DEF_MAX_STAGES + 39 + 9;
   localparam longint U32_MAX     = 64'h0000_0000_FFFF_FFFF;
   localparam logic [31:0] Q16_ONE  = 32'h0001_0000;
   localparam logic [31:0] S32_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN  = 32'h8000_0000;

   // One full register set, written in index order
   typedef struct packed {
      logic [3:0][31:0] weight;
      logic [31:0]      stages;
      logic [31:0]      goal;
      logic [31:0]      step;
   } csr_set_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_data  = '0;

   // Predictor state
   logic [31:0]        step_q;
   logic [31:0]        goal_q;
   logic [2:0]         stage_cnt_q;
   logic signed [15:0] weight_q [4];
   logic [31:0]        running_max_q;

   rsp_type     pending_criteria [$];
   rsp_type     want;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;

   max_relative_change_check_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** max_relative_change_check_core: FAILED **");
      $finish;
   end

   function automatic longint clamp_s32(input longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (x < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
      return x;
   endfunction

   // Advance the running maximum by one element; queue a criterion on the last one
   function automatic void track_relative_change(input req_type e);
      logic signed [31:0] slopes [4];
      int unsigned n;
      int unsigned s;
      longint coef, sum, change, absc, old_t, new_t, denom, ratio, crit;
      rsp_type r;
      slopes[0] = e.slope_stage0;
      slopes[1] = e.slope_stage1;
      slopes[2] = e.slope_stage2;
      slopes[3] = e.slope_stage3;
      n = stage_cnt_q;
      if (n < 1) n = 1;
      if (n > DEF_MAX_STAGES) n = DEF_MAX_STAGES;
      sum = 0;
      for (s = 0; s < n; s++) begin
         coef = clamp_s32((longint'(weight_q[s]) * longint'(step_q)) >>> 14);
         sum += (coef * longint'(slopes[s])) >>> 16;
      end
      change = clamp_s32(sum);
      absc   = (change < 0) ? -change : change;
      old_t  = longint'(e.old_temperature);
      new_t  = old_t + change;
      denom  = ((old_t < 0) ? -old_t : old_t) + ((new_t < 0) ? -new_t : new_t);
      if (denom < longint'(MIN_DENOM)) denom = longint'(MIN_DENOM);
      ratio = (absc << 16) / denom;
      if (ratio > U32_MAX) ratio = U32_MAX;
      if (ratio > longint'(running_max_q)) running_max_q = ratio[31:0];
      if (e.last_element) begin
         crit = longint'(running_max_q) * 2;
         if (crit > U32_MAX) crit = U32_MAX;
         r.criterion = crit[31:0];
         r.too_big   = (crit * 5 > longint'(goal_q) * 6);
         pending_criteria.push_back(r);
         running_max_q = '0;
      end
   endfunction

   // Write one register and mirror it; csr_valid stays high for the caller to drop
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_STEP_SIZE:   step_q      = value;
         REG_CHANGE_GOAL: goal_q      = value;
         REG_STAGE_COUNT: stage_cnt_q = value[2:0];
         REG_WEIGHT0:     weight_q[0] = value[15:0];
         REG_WEIGHT1:     weight_q[1] = value[15:0];
         REG_WEIGHT2:     weight_q[2] = value[15:0];
         REG_WEIGHT3:     weight_q[3] = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(input csr_set_type c);
      write_csr(REG_STEP_SIZE, c.step);
      write_csr(REG_CHANGE_GOAL, c.goal);
      write_csr(REG_STAGE_COUNT, c.stages);
      write_csr(REG_WEIGHT0, c.weight[0]);
      write_csr(REG_WEIGHT1, c.weight[1]);
      write_csr(REG_WEIGHT2, c.weight[2]);
      write_csr(REG_WEIGHT3, c.weight[3]);
      // unmapped index: must leave every register alone
      write_csr(REG_UNMAPPED, $urandom);
      csr_valid <= 1'b0;
   endtask

   // Send one element; keep valid high when the next one follows at once
   task automatic send_element(input req_type e);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_relative_change(e);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every criterion is in and the last element has retired
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_criteria.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type element(input logic [31:0] old_t, input logic [31:0] s0,
                                       input logic [31:0] s1, input logic [31:0] s2,
                                       input logic [31:0] s3, input logic last);
      req_type e;
      e.old_temperature = old_t;
      e.slope_stage0    = s0;
      e.slope_stage1    = s1;
      e.slope_stage2    = s2;
      e.slope_stage3    = s3;
      e.last_element    = last;
      return e;
   endfunction

   function automatic csr_set_type base_settings();
      csr_set_type c;
      c.step      = RST_STEP_SIZE;
      c.goal      = RST_CHANGE_GOAL;
      c.stages    = 32'(RST_STAGE_COUNT);
      c.weight[0] = 32'(RST_WEIGHT0);
      c.weight[1] = 32'(RST_WEIGHT_REST);
      c.weight[2] = 32'(RST_WEIGHT_REST);
      c.weight[3] = 32'(RST_WEIGHT_REST);
      return c;
   endfunction

   // Spread magnitudes over the whole range, with the extremes now and then
   function automatic logic [31:0] rand_q16();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(15))
         0:       v = S32_MAX;
         1:       v = S32_MIN;
         2:       v = '0;
         3, 4, 5: ;
         default: v = $signed(v) >>> $urandom_range(31);
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_unsigned();
      logic [31:0] v;
      case ($urandom_range(7))
         0:       v = 32'hFFFF_FFFF;
         1:       v = '0;
         2:       v = Q16_ONE;
         3:       v = $urandom;
         default: v = $urandom >> $urandom_range(31);
      endcase
      return v;
   endfunction

   function automatic csr_set_type rand_settings();
      csr_set_type c;
      int unsigned k;
      c.step = rand_unsigned();
      if (c.step == '0 && $urandom_range(3) != 0) c.step = Q16_ONE;
      c.goal   = rand_unsigned();
      c.stages = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(1, 4));
      for (k = 0; k < 4; k++) begin
         case ($urandom_range(5))
            0:       c.weight[k] = 32'h0000_7FFF;
            1:       c.weight[k] = 32'hFFFF_8000;
            2:       c.weight[k] = 32'(RST_WEIGHT0);
            default: c.weight[k] = $urandom;
         endcase
      end
      return c;
   endfunction

   // Drive receiver stall and check each criterion transaction
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_criteria.size() == 0) begin
            $error("unexpected result: criterion %h too_big %b",
                   rsp_data.criterion, rsp_data.too_big);
            mismatch_count++;
         end else begin
            want = pending_criteria.pop_front();
            if (rsp_data.criterion !== want.criterion) begin
               $error("criterion: expected %h, actual %h", want.criterion, rsp_data.criterion);
               mismatch_count++;
            end
            if (rsp_data.too_big !== want.too_big) begin
               $error("too_big: expected %b, actual %b", want.too_big, rsp_data.too_big);
               mismatch_count++;
            end
         end
      end
   end

   // Register defaults straight out of reset
   task automatic test_reset_defaults();
      send_element(element(Q16_ONE, 32'h0000_8000, $urandom, $urandom, $urandom, 1'b0));
      send_element(element('0, '0, $urandom, $urandom, $urandom, 1'b1));
   endtask

   // Saturated coefficients, extreme temperatures and slopes, zero and full goal
   task automatic test_field_extremes();
      csr_set_type c;
      c           = base_settings();
      c.step      = 32'hFFFF_FFFF;
      c.goal      = '0;
      c.stages    = 32'd4;
      c.weight[0] = 32'h0000_7FFF;
      c.weight[1] = 32'hFFFF_8000;
      c.weight[2] = 32'h0000_7FFF;
      c.weight[3] = 32'hFFFF_8000;
      settle();
      program_settings(c);
      send_element(element(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 1'b0));
      send_element(element(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1'b0));
      send_element(element('0, 32'd1, '0, '0, '0, 1'b1));
      send_element(element('0, '0, '0, '0, '0, 1'b1));
      c.step = 32'd1;
      c.goal = 32'hFFFF_FFFF;
      settle();
      program_settings(c);
      send_element(element('0, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1'b1));
   endtask

   // Stage count of zero and above the maximum, with high data bits set
   task automatic test_stage_count_range();
      csr_set_type c;
      logic [31:0] counts [3];
      int unsigned k;
      counts[0] = 32'hFFFF_FFF8;
      counts[1] = 32'd5;
      counts[2] = 32'hFFFF_FFFF;
      c = base_settings();
      c.weight = {4{32'(RST_WEIGHT0)}};
      for (k = 0; k < 3; k++) begin
         c.stages = counts[k];
         settle();
         program_settings(c);
         send_element(element(Q16_ONE, 32'h1000, 32'h2000, 32'h4000, 32'h8000, 1'b1));
      end
   endtask

   // Zero step size: no change at all
   task automatic test_zero_step();
      csr_set_type c;
      c        = base_settings();
      c.step   = '0;
      c.stages = 32'd4;
      settle();
      program_settings(c);
      send_element(element(S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 1'b0));
      send_element(element('0, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1'b1));
   endtask

   // Floor on the denominator and the threshold at exactly 1.2 times the goal
   task automatic test_threshold_edge();
      csr_set_type c;
      c      = base_settings();
      c.goal = 32'd109227;
      settle();
      program_settings(c);
      send_element(element('0, 32'd1, '0, '0, '0, 1'b1));
      send_element(element('0, 32'd1, '0, '0, '0, 1'b0));
      send_element(element('0, Q16_ONE, '0, '0, '0, 1'b1));
      c.goal = 32'd109226;
      settle();
      program_settings(c);
      send_element(element('0, Q16_ONE, '0, '0, '0, 1'b1));
   endtask

   // Random checks of random length under random settings
   task automatic test_random_stream(input int unsigned n_items, input int unsigned send_pct,
                                     input int unsigned recv_pct);
      int unsigned sent;
      int unsigned since_cfg;
      int unsigned group_len;
      int unsigned i;
      settle();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      program_settings(rand_settings());
      sent      = 0;
      since_cfg = 0;
      while (sent < n_items) begin
         if (since_cfg > 60) begin
            settle();
            program_settings(rand_settings());
            since_cfg = 0;
         end
         group_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (i = 0; i < group_len; i++) begin
            send_element(element(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                                 i == group_len - 1));
         end
         sent      += group_len;
         since_cfg += group_len;
      end
   endtask

   initial begin
      step_q        = RST_STEP_SIZE;
      goal_q        = RST_CHANGE_GOAL;
      stage_cnt_q   = RST_STAGE_COUNT;
      weight_q[0]   = RST_WEIGHT0;
      weight_q[1]   = RST_WEIGHT_REST;
      weight_q[2]   = RST_WEIGHT_REST;
      weight_q[3]   = RST_WEIGHT_REST;
      running_max_q = '0;
      send_idle_pct = 19;
      recv_idle_pct = 80;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_stage_count_range();
      test_zero_step();
      test_threshold_edge();
      test_random_stream(380, 19, 80);
      test_random_stream(380, 80, 19);
      test_random_stream(380, 0, 0);
      settle();

      if (mismatch_count == 0) begin
         $display("** max_relative_change_check_core: PASSED **");
      end else begin
         $display("** max_relative_change_check_core: FAILED **");
      end
      $finish;
   end

endmodule

FILE: max_relative_change_check_core.f
rtl/mrcc_pkg.sv
rtl/mrcc_csr.sv
rtl/mrcc_mac.sv
rtl/mrcc_div.sv
rtl/max_relative_change_check_core.sv
tb/max_relative_change_check_core_tb.sv
